// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers. They use the enclosing module's clk; ASSERT_CLK also uses rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/utf8vd_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8vd_pkg
// Types, constants and helpers shared by the UTF-8 decoder files.
// ----------------------------------------------------------------------------
package utf8vd_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int START_BITS  = 24;
    localparam int CP_BITS     = 21;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [START_BITS-1:0]  start_t;
    typedef logic [CP_BITS-1:0]     cp_t;

    typedef enum logic [1:0] {
        STATUS_VALID   = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_NUL     = 2'd2
    } status_t;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam cp_t MIN_CP2       = 21'h00080;
    localparam cp_t MIN_CP3       = 21'h00800;
    localparam cp_t MIN_CP4       = 21'h10000;
    localparam cp_t SURROGATE_LO  = 21'h0D800;
    localparam cp_t SURROGATE_HI  = 21'h0DFFF;
    localparam cp_t MAX_CP        = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        cp_t     code_point;
        status_t status;
        start_t  start_offset;
        logic    end_of_text;
    } result_word_t;

    typedef struct packed {
        logic advance;
        logic fire;
    } pipe_ctrl_t;

    typedef struct packed {
        logic         produced;
        result_word_t word;
    } decode_result_t;

    function automatic cp_t min_code_point(input logic [2:0] seq_len);
        cp_t m;
        unique case (seq_len)
            3'd2:    m = MIN_CP2;
            3'd3:    m = MIN_CP3;
            default: m = MIN_CP4;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/utf8vd_byte_if.sv -----
// ----------------------------------------------------------------------------
// utf8vd_byte_if
// Byte channel: one text byte per word, with the final-byte flag.
// ----------------------------------------------------------------------------
interface utf8vd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// ----- sv/utf8vd_result_if.sv -----
// ----------------------------------------------------------------------------
// utf8vd_result_if
// Result channel: one decoded code point or error report per word.
// ----------------------------------------------------------------------------
interface utf8vd_result_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [1:0]  status;
    logic [23:0] start_offset;
    logic        end_of_text;

    modport source (output valid, output code_point, output status,
                    output start_offset, output end_of_text, input ready);
    modport sink   (input valid, input code_point, input status,
                    input start_offset, input end_of_text, output ready);
endinterface

// ----- sv/utf8vd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// utf8vd_cfg_if
// Configuration write channel for the reject_nul register.
// ----------------------------------------------------------------------------
interface utf8vd_cfg_if;
    logic valid;
    logic ready;
    logic reject_nul;

    modport source (output valid, output reject_nul, input ready);
    modport sink   (input valid, input reject_nul, output ready);
endinterface

// ----- sv/utf8_validating_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_validating_decoder
// Streaming validating UTF-8 decoder, one text byte per word.
// ----------------------------------------------------------------------------
// Takes one byte per cycle sustained while the result sink takes results; a
// held result stalls the input. A byte passes an input register, then one
// decode step that reads and updates the per-text state, then a result
// register, loaded when the step produces a result word. The rate is set by
// the update of the decode state, which every byte goes through in order.
// reject_nul resets to 1; the user must write it only while the block is
// idle; the block does not enforce this. Its write channel is always ready.
module utf8_validating_decoder (
    input  logic          clk,
    input  logic          rst_n,
    utf8vd_byte_if.sink   text,
    utf8vd_result_if.source result,
    utf8vd_cfg_if.sink    cfg
);
    import utf8vd_pkg::*;

    logic           reject_nul_reg;
    logic           s1_valid;
    byte_word_t     s1_word;
    logic           advance;
    pipe_ctrl_t     ctrl;
    decode_result_t res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reject_nul_reg <= 1'b1;
        else if (cfg.valid)
            reject_nul_reg <= cfg.reject_nul;
    end

    assign ctrl.advance = advance;
    assign ctrl.fire    = s1_valid && advance;

    utf8vd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .ctrl     (ctrl),
        .s1_valid (s1_valid),
        .s1_word  (s1_word)
    );

    utf8vd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (ctrl.fire),
        .s1_word    (s1_word),
        .reject_nul (reject_nul_reg),
        .res        (res)
    );

    utf8vd_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (ctrl.fire),
        .res     (res),
        .advance (advance),
        .result  (result)
    );

endmodule

// ----- sv/utf8vd_in_reg.sv -----
// ----------------------------------------------------------------------------
// utf8vd_in_reg
// Input register stage. Holds one byte word ahead of the decode step.
// ----------------------------------------------------------------------------
module utf8vd_in_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    utf8vd_byte_if.sink             text,
    input  utf8vd_pkg::pipe_ctrl_t  ctrl,
    output logic                    s1_valid,
    output utf8vd_pkg::byte_word_t  s1_word
);
    import utf8vd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_word_t word_reg;
    logic       accept;

    assign text.ready = !valid_reg || ctrl.advance;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (ctrl.advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.byte_value <= text.byte_value;
            word_reg.last_byte  <= text.last_byte;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_word  = word_reg;

endmodule

// ----- sv/utf8vd_decode.sv -----
// ----------------------------------------------------------------------------
// utf8vd_decode
// Per-text decode state and the single-byte decode and validation step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8vd_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  utf8vd_pkg::byte_word_t     s1_word,
    input  logic                       reject_nul,
    output utf8vd_pkg::decode_result_t res
);
    import utf8vd_pkg::*;

    cp_t        partial_reg, partial_next;
    logic [1:0] left_reg, left_next;
    logic [2:0] seq_len_reg, seq_len_next;
    offset_t    seq_start_reg, seq_start_next;
    offset_t    count_reg, count_next;
    logic       abandoned_reg, abandoned_next;

    logic [7:0] b;
    logic       last;
    logic       err;
    logic       done;
    status_t    st;
    cp_t        cp;
    cp_t        assembled;
    offset_t    start;
    logic [2:0] lead_len;
    cp_t        lead_init;

    assign b         = s1_word.byte_value;
    assign last      = s1_word.last_byte;
    assign assembled = {partial_reg[CP_BITS-7:0], b[5:0]};

    always_comb
    begin
        partial_next   = partial_reg;
        left_next      = left_reg;
        seq_len_next   = seq_len_reg;
        seq_start_next = seq_start_reg;
        count_next     = count_reg;
        abandoned_next = abandoned_reg;
        err            = 1'b0;
        done           = 1'b0;
        st             = STATUS_VALID;
        cp             = '0;
        start          = count_reg;
        lead_len       = 3'd0;
        lead_init      = '0;

        priority if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            lead_len  = 3'd2;
            lead_init = cp_t'(b[4:0]);
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            lead_len  = 3'd3;
            lead_init = cp_t'(b[3:0]);
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            lead_len  = 3'd4;
            lead_init = cp_t'(b[2:0]);
        end
        else
        begin
            lead_len  = 3'd0;
            lead_init = '0;
        end

        if (!abandoned_reg)
        begin
            if (left_reg == 2'd0)
            begin
                if (!b[7])
                begin
                    cp   = cp_t'(b);
                    done = 1'b1;
                end
                else if (lead_len == 3'd0 || last)
                begin
                    err = 1'b1;
                    st  = STATUS_INVALID;
                end
                else
                begin
                    partial_next   = lead_init;
                    left_next      = 2'(lead_len - 3'd1);
                    seq_len_next   = lead_len;
                    seq_start_next = count_reg;
                end
            end
            else
            begin
                start = seq_start_reg;
                if (b[7:6] != 2'b10)
                begin
                    err = 1'b1;
                    st  = STATUS_INVALID;
                end
                else
                begin
                    partial_next = assembled;
                    left_next    = left_reg - 2'd1;
                    if (left_reg == 2'd1)
                    begin
                        cp = assembled;
                        if (assembled < min_code_point(seq_len_reg) ||
                            (assembled >= SURROGATE_LO && assembled <= SURROGATE_HI) ||
                            assembled > MAX_CP)
                        begin
                            err = 1'b1;
                            st  = STATUS_INVALID;
                        end
                        else
                            done = 1'b1;
                    end
                    else if (last)
                    begin
                        err = 1'b1;
                        st  = STATUS_INVALID;
                    end
                end
            end

            if (done && cp == '0 && reject_nul)
            begin
                err  = 1'b1;
                st   = STATUS_NUL;
                done = 1'b0;
            end

            if (done)
            begin
                left_next    = 2'd0;
                seq_len_next = 3'd0;
                partial_next = '0;
            end
        end

        if (last)
        begin
            partial_next   = '0;
            left_next      = 2'd0;
            seq_len_next   = 3'd0;
            seq_start_next = '0;
            count_next     = '0;
            abandoned_next = 1'b0;
        end
        else
        begin
            if (err)
            begin
                abandoned_next = 1'b1;
                left_next      = 2'd0;
                seq_len_next   = 3'd0;
                partial_next   = '0;
            end
            if (count_reg != '1)
                count_next = count_reg + offset_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            left_reg      <= 2'd0;
            seq_len_reg   <= 3'd0;
            seq_start_reg <= '0;
            count_reg     <= '0;
            abandoned_reg <= 1'b0;
        end
        else if (fire)
        begin
            partial_reg   <= partial_next;
            left_reg      <= left_next;
            seq_len_reg   <= seq_len_next;
            seq_start_reg <= seq_start_next;
            count_reg     <= count_next;
            abandoned_reg <= abandoned_next;
        end
    end

    assign res.produced          = err || done;
    assign res.word.code_point   = err ? '0 : cp;
    assign res.word.status       = st;
    assign res.word.start_offset = start_t'(start);
    assign res.word.end_of_text  = last;

    `ASSERT_CLK(a_last_clears,
        fire && last |=> count_reg == '0 && !abandoned_reg && left_reg == 2'd0,
        "final byte did not clear text state")
    `ASSERT_CLK(a_abandoned_quiet,
        fire && abandoned_reg |-> !res.produced,
        "result produced in abandoned text")
    `ASSERT_ALWAYS(a_err_zero_cp,
        res.produced && res.word.status != STATUS_VALID |-> res.word.code_point == '0,
        "error result carries a code point")
    `ASSERT_CLK(a_open_not_abandoned,
        left_reg != 2'd0 |-> !abandoned_reg && seq_len_reg != 3'd0,
        "open sequence in abandoned text")

endmodule

// ----- sv/utf8vd_out_reg.sv -----
// ----------------------------------------------------------------------------
// utf8vd_out_reg
// Result register. Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8vd_out_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  utf8vd_pkg::decode_result_t res,
    output logic                       advance,
    utf8vd_result_if.source            result
);
    import utf8vd_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    result_word_t word_reg;
    logic         load;

    assign advance = !valid_reg || result.ready;
    assign load    = fire && res.produced;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= res.word;
    end

    assign result.valid        = valid_reg;
    assign result.code_point   = word_reg.code_point;
    assign result.status       = word_reg.status;
    assign result.start_offset = word_reg.start_offset;
    assign result.end_of_text  = word_reg.end_of_text;

    `ASSERT_CLK(a_no_overwrite, valid_reg && !result.ready |-> !fire, "held result overwritten")

endmodule
